// ----- sv/framed_message_ring_buffer_top_assert.svh -----
// Assertion macros used by the ring buffer controller.
`ifndef FRAMED_MESSAGE_RING_BUFFER_TOP_ASSERT_SVH
`define FRAMED_MESSAGE_RING_BUFFER_TOP_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define FMRB_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define FMRB_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/fmrb_pkg.sv -----
`default_nettype none
package fmrb_pkg;

  localparam int RING_BYTES   = 4096;
  localparam int LINE_BYTES   = 64;
  localparam int HEADER_BYTES = 4;

  localparam int PTR_W     = $clog2(RING_BYTES);
  localparam int USED_W    = PTR_W + 1;
  localparam int LINE_LSB  = $clog2(LINE_BYTES);
  localparam int LEN_W     = 12;
  localparam int LIMIT_W   = 13;
  localparam int CNT_W     = 13;
  localparam int PAD_W     = $clog2(HEADER_BYTES + (1 << LEN_W) + LINE_BYTES);
  localparam int HDR_IDX_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int HDR_BITS  = HEADER_BYTES * 8;
  localparam int CMP_W     = ((LIMIT_W > PAD_W) ? LIMIT_W : PAD_W) + USED_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2048);

  typedef enum logic [1:0] {
    MODE_BEGIN   = 2'd0,
    MODE_PAYLOAD = 2'd1,
    MODE_FETCH   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REJECT  = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_SEQ_ERR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_HEADER
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LEN_W-1:0] msg_len;
    logic [7:0]       payload_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic    clr_wr;
    logic    latch;
    logic    begin_ok;
    logic    payload_wr;
    logic    fetch_rd;
    logic    fetch_clr;
    logic    hdr_wr;
    logic    res_valid;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       hdr_last;
    logic       insert_open;
    logic       empty;
    logic       reject;
    logic [1:0] mode;
  } stat_t;

endpackage
`default_nettype wire

// ----- sv/fmrb_ctrl.sv -----
`default_nettype none
`include "framed_message_ring_buffer_top_assert.svh"
module fmrb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire fmrb_pkg::stat_t stat_i,
  output fmrb_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  fmrb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmrb_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fmrb_pkg::S_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = fmrb_pkg::S_IDLE;
        end
      end
      fmrb_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = fmrb_pkg::S_EXEC;
        end
      end
      fmrb_pkg::S_EXEC: begin
        state_d = fmrb_pkg::S_IDLE;
        case (stat_i.mode)
          fmrb_pkg::MODE_BEGIN: begin
            if (!stat_i.insert_open && !stat_i.reject) begin
              state_d = fmrb_pkg::S_HEADER;
            end
          end
          fmrb_pkg::MODE_FETCH: begin
            if (!stat_i.insert_open && !stat_i.empty) begin
              state_d = fmrb_pkg::S_FETCH;
            end
          end
          default: begin
            state_d = fmrb_pkg::S_IDLE;
          end
        endcase
      end
      fmrb_pkg::S_FETCH: begin
        state_d = fmrb_pkg::S_IDLE;
      end
      fmrb_pkg::S_HEADER: begin
        if (stat_i.hdr_last) begin
          state_d = fmrb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fmrb_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = fmrb_pkg::STAT_OK;
    busy_o = (state_q != fmrb_pkg::S_IDLE);
    case (state_q)
      fmrb_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      fmrb_pkg::S_IDLE: begin
        cmd_o.latch = start_i;
      end
      fmrb_pkg::S_EXEC: begin
        case (stat_i.mode)
          fmrb_pkg::MODE_BEGIN: begin
            cmd_o.res_valid = 1'b1;
            if (stat_i.insert_open) begin
              cmd_o.res_status = fmrb_pkg::STAT_SEQ_ERR;
            end else if (stat_i.reject) begin
              cmd_o.res_status = fmrb_pkg::STAT_REJECT;
            end else begin
              cmd_o.begin_ok = 1'b1;
            end
          end
          fmrb_pkg::MODE_PAYLOAD: begin
            cmd_o.res_valid = 1'b1;
            if (!stat_i.insert_open) begin
              cmd_o.res_status = fmrb_pkg::STAT_SEQ_ERR;
            end else begin
              cmd_o.payload_wr = 1'b1;
            end
          end
          fmrb_pkg::MODE_FETCH: begin
            if (stat_i.insert_open) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_status = fmrb_pkg::STAT_SEQ_ERR;
            end else if (stat_i.empty) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_status = fmrb_pkg::STAT_EMPTY;
            end else begin
              cmd_o.fetch_rd = 1'b1;
            end
          end
          default: begin
            cmd_o.res_valid  = 1'b1;
            cmd_o.res_status = fmrb_pkg::STAT_SEQ_ERR;
          end
        endcase
      end
      fmrb_pkg::S_FETCH: begin
        cmd_o.fetch_clr = 1'b1;
        cmd_o.res_valid = 1'b1;
      end
      fmrb_pkg::S_HEADER: begin
        cmd_o.hdr_wr = 1'b1;
      end
      default: begin
        cmd_o.clr_wr = 1'b0;
      end
    endcase
  end

  `FMRB_ASSERT_IMPL(a_fetch_after_exec, clk_i, rst_ni, state_q == fmrb_pkg::S_FETCH,
      $past(state_q) == fmrb_pkg::S_EXEC, "fetch clear without a preceding read")
  `FMRB_ASSERT(a_one_writer, clk_i, rst_ni,
      $onehot0({cmd_o.clr_wr, cmd_o.hdr_wr, cmd_o.payload_wr, cmd_o.fetch_clr}),
      "more than one ring write source active")
  `FMRB_ASSERT_IMPL(a_no_result_in_clear, clk_i, rst_ni, state_q == fmrb_pkg::S_CLEAR,
      !cmd_o.res_valid && !busy_o == 1'b0, "result issued during clearing pass")

endmodule
`default_nettype wire

// ----- sv/fmrb_datapath.sv -----
`default_nettype none
module fmrb_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire fmrb_pkg::in_word_t               item_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [fmrb_pkg::LIMIT_W-1:0]     cfg_wdata_i,
  input  wire fmrb_pkg::cmd_t                   cmd_i,
  output fmrb_pkg::stat_t                       stat_o,
  output logic                                  res_valid_o,
  output fmrb_pkg::out_word_t                   res_o
);

  localparam int PTR_W = fmrb_pkg::PTR_W;

  logic [7:0] ring_mem [fmrb_pkg::RING_BYTES];

  fmrb_pkg::in_word_t                item_q;
  logic [7:0]                        rd_data_q;
  logic [fmrb_pkg::PAD_W-1:0]        hdr_val_q;
  logic [PTR_W-1:0]                  hdr_base_q;
  fmrb_pkg::out_word_t               res_q;

  logic [fmrb_pkg::LIMIT_W-1:0]      limit_q;
  logic [PTR_W-1:0]                  clr_ptr_q;
  logic [fmrb_pkg::HDR_IDX_W-1:0]    hdr_idx_q;
  logic [PTR_W-1:0]                  head_q;
  logic [PTR_W-1:0]                  reserve_q;
  logic [PTR_W-1:0]                  commit_q;
  logic [PTR_W-1:0]                  write_ptr_q;
  logic [fmrb_pkg::CNT_W-1:0]        bytes_left_q;
  logic                              insert_open_q;
  logic                              res_valid_q;

  logic [PTR_W-1:0]                  used;
  logic [fmrb_pkg::PAD_W-1:0]        pad_sum;
  logic [fmrb_pkg::PAD_W-1:0]        padded;
  logic [fmrb_pkg::CMP_W-1:0]        free_cnt;
  logic                              limit_hit;
  logic                              no_room;
  logic [PTR_W-1:0]                  reserve_next;
  logic [PTR_W-1:0]                  head_next;
  logic [fmrb_pkg::HDR_BITS+fmrb_pkg::PAD_W-1:0] hdr_ext;

  logic                              wr_en;
  logic [PTR_W-1:0]                  wr_addr;
  logic [7:0]                        wr_data;

  assign used     = reserve_q - head_q;
  assign pad_sum  = fmrb_pkg::PAD_W'(fmrb_pkg::HEADER_BYTES) + fmrb_pkg::PAD_W'(item_q.msg_len)
                  + fmrb_pkg::PAD_W'(fmrb_pkg::LINE_BYTES - 1);
  assign padded   = {pad_sum[fmrb_pkg::PAD_W-1:fmrb_pkg::LINE_LSB],
                     fmrb_pkg::LINE_LSB'(0)};
  assign free_cnt = fmrb_pkg::CMP_W'(fmrb_pkg::RING_BYTES) - fmrb_pkg::CMP_W'(used);
  assign limit_hit = fmrb_pkg::CMP_W'(used) >= fmrb_pkg::CMP_W'(limit_q);
  assign no_room   = fmrb_pkg::CMP_W'(padded) >= free_cnt;
  assign reserve_next = reserve_q + padded[PTR_W-1:0];
  assign head_next    = head_q + PTR_W'(1);
  assign hdr_ext      = {{fmrb_pkg::HDR_BITS{1'b0}}, hdr_val_q};

  always_comb begin
    stat_o.clr_last    = (clr_ptr_q == PTR_W'(fmrb_pkg::RING_BYTES - 1));
    stat_o.hdr_last    = (hdr_idx_q == fmrb_pkg::HDR_IDX_W'(fmrb_pkg::HEADER_BYTES - 1));
    stat_o.insert_open = insert_open_q;
    stat_o.empty       = (head_q == commit_q);
    stat_o.reject      = limit_hit || no_room;
    stat_o.mode        = item_q.mode;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head_q;
    wr_data = 8'd0;
    if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_ptr_q;
    end else if (cmd_i.hdr_wr) begin
      wr_en   = 1'b1;
      wr_addr = hdr_base_q + PTR_W'(hdr_idx_q);
      wr_data = hdr_ext[hdr_idx_q*8 +: 8];
    end else if (cmd_i.payload_wr) begin
      wr_en   = 1'b1;
      wr_addr = write_ptr_q;
      wr_data = item_q.payload_byte;
    end else if (cmd_i.fetch_clr) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.fetch_rd) begin
      rd_data_q <= ring_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= item_i;
    end
    if (cmd_i.begin_ok) begin
      hdr_val_q  <= padded;
      hdr_base_q <= reserve_q;
    end
    if (cmd_i.res_valid) begin
      res_q.status    <= cmd_i.res_status;
      res_q.data_byte <= cmd_i.fetch_clr ? rd_data_q : 8'd0;
      res_q.last      <= cmd_i.fetch_clr && (head_next == commit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= fmrb_pkg::LIMIT_RESET;
      clr_ptr_q     <= '0;
      hdr_idx_q     <= '0;
      head_q        <= '0;
      reserve_q     <= '0;
      commit_q      <= '0;
      write_ptr_q   <= '0;
      bytes_left_q  <= '0;
      insert_open_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.res_valid;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_wr) begin
        clr_ptr_q <= clr_ptr_q + PTR_W'(1);
      end
      if (cmd_i.hdr_wr) begin
        hdr_idx_q <= hdr_idx_q + fmrb_pkg::HDR_IDX_W'(1);
      end
      if (cmd_i.begin_ok) begin
        hdr_idx_q    <= '0;
        write_ptr_q  <= reserve_q + PTR_W'(fmrb_pkg::HEADER_BYTES);
        reserve_q    <= reserve_next;
        bytes_left_q <= fmrb_pkg::CNT_W'(item_q.msg_len);
        if (item_q.msg_len == '0) begin
          commit_q <= reserve_next;
        end else begin
          insert_open_q <= 1'b1;
        end
      end
      if (cmd_i.payload_wr) begin
        write_ptr_q  <= write_ptr_q + PTR_W'(1);
        bytes_left_q <= bytes_left_q - fmrb_pkg::CNT_W'(1);
        if (bytes_left_q == fmrb_pkg::CNT_W'(1)) begin
          commit_q      <= reserve_q;
          insert_open_q <= 1'b0;
        end
      end
      if (cmd_i.fetch_clr) begin
        head_q <= head_next;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ----- sv/framed_message_ring_buffer_top.sv -----
// Channel   Direction  Handshake                 Payload
// command   in         start_i high, busy_o low  item_i (mode, msg_len, payload_byte)
// result    out        res_valid_o, one cycle    res_o (status, data_byte, last)
// config    in         cfg_we_i                  cfg_wdata_i (forward_limit)
//
// A payload word or a refused word passes through the execute state only, a fetch
// reads and then clears (on the ring's single write port), and an accepted begin
// then writes the header one byte per cycle.
// After reset the ring is cleared one byte per cycle, with busy_o high.
// The result is registered and appears in the cycle after the deciding cycle; it cannot be stalled.
`default_nettype none
module framed_message_ring_buffer_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire fmrb_pkg::in_word_t           item_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [fmrb_pkg::LIMIT_W-1:0] cfg_wdata_i,
  output logic                              res_valid_o,
  output fmrb_pkg::out_word_t               res_o
);

  fmrb_pkg::cmd_t  cmd;
  fmrb_pkg::stat_t stat;

  fmrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  fmrb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
